// File: hw/rtl/cio_pkg.sv
// ----------------------------------------------------------------------------
// cio_pkg
// Shared types and constants for the console I/O port block.
// ----------------------------------------------------------------------------
package cio_pkg;

  // port select codes
  typedef enum logic [2:0] {
    PortPanel  = 3'd0,
    PortRight  = 3'd1,
    PortLeft   = 3'd2,
    PortRow    = 3'd3,
    PortRamCtl = 3'd4,
    PortRamAdr = 3'd5
  } port_sel_e;

  // access commands
  typedef enum logic {
    CmdRead  = 1'b0,
    CmdWrite = 1'b1
  } cmd_e;

  // cartridge bit ram geometry
  localparam int RamBits = 1024;
  localparam int RamAw   = $clog2(RamBits);

  // screen geometry
  localparam int ScreenColumns = 128;
  localparam int ColW          = $clog2(ScreenColumns);
  localparam int RowW          = 6;
  localparam int ColorW        = 2;
  localparam int ToneW         = 2;

  // pin and latch constants
  localparam logic [7:0] PadMaskOr = 8'hc0;
  localparam logic [7:0] BusIdle   = 8'hff;
  localparam int         MaskBit   = 6;
  localparam int         PixelBit  = 5;

endpackage

// File: hw/rtl/console_io_port_block.sv
// ----------------------------------------------------------------------------
// console_io_port_block
// Six-port console I/O block: pin reads, pixel and tone writes, cart bit ram.
// ----------------------------------------------------------------------------
// stages: an accepted word passes the input reg, then the result reg
// throughput: one word per cycle outside the ram clearing pass; the result reg and input reg stall together
// reset: port latches, pixel and address state and valid flags clear; the 1024x1
//   cart ram is then cleared by a pass, one bit a cycle, during which in_stall_o is high
// ram read data is registered and tracks the current ram address every cycle
module console_io_port_block (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      command_i,
  input  logic [2:0]                port_select_i,
  input  logic [7:0]                write_value_i,
  input  logic [7:0]                panel_pins_i,
  input  logic [7:0]                right_pad_pins_i,
  input  logic [7:0]                left_pad_pins_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                read_value_o,
  output logic                      pixel_write_o,
  output logic [cio_pkg::RowW-1:0]  pixel_row_o,
  output logic [cio_pkg::ColW-1:0]  pixel_column_o,
  output logic [cio_pkg::ColorW-1:0] pixel_color_o,
  output logic                      tone_write_o,
  output logic [cio_pkg::ToneW-1:0] tone_value_o
);
  import cio_pkg::*;

  // handshake and pipeline control
  logic             s1_valid_q;
  logic             out_valid_q;
  logic             out_free;
  logic             s1_move;
  logic             in_take;
  logic [RamAw:0]   clr_cnt_q;
  logic             clearing;

  // input register
  logic             s1_cmd_q;
  logic [2:0]       s1_sel_q;
  logic [7:0]       s1_data_q;
  logic [7:0]       s1_panel_q;
  logic [7:0]       s1_right_q;
  logic [7:0]       s1_left_q;

  // architectural state
  logic [7:0]        latch_q [6];
  logic [7:0]        latch_d [6];
  logic [ColorW-1:0] color_q, color_d;
  logic [ColW-1:0]   column_q, column_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [RamAw-1:0]  addr_q, addr_d;
  logic              wmode_q, wmode_d;

  // cart ram
  logic              ram_mem [RamBits];
  logic              ram_raw_q;
  logic              ram_byp_q;
  logic              ram_byp_dat_q;
  logic              ram_bit;
  logic              ram_we;
  logic [RamAw-1:0]  ram_waddr;
  logic              ram_wdat;
  logic              cmt_we;

  // result next values
  logic [7:0]        rd_val_d;
  logic              pix_we_d;
  logic [RowW-1:0]   pix_row_d;
  logic [ColW-1:0]   pix_col_d;
  logic [ColorW-1:0] pix_color_d;
  logic              tone_we_d;
  logic [ToneW-1:0]  tone_val_d;
  logic              mask;
  port_sel_e         sel;

  // result register
  logic [7:0]        rd_val_q;
  logic              pix_we_q;
  logic [RowW-1:0]   pix_row_q;
  logic [ColW-1:0]   pix_col_q;
  logic [ColorW-1:0] pix_color_q;
  logic              tone_we_q;
  logic [ToneW-1:0]  tone_val_q;

  // flow control
  assign clearing   = ~clr_cnt_q[RamAw];
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign s1_move    = s1_valid_q & out_free;
  assign in_stall_o = clearing | (s1_valid_q & ~out_free);
  assign in_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // input register load
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q   <= command_i;
      s1_sel_q   <= port_select_i;
      s1_data_q  <= write_value_i;
      s1_panel_q <= panel_pins_i;
      s1_right_q <= right_pad_pins_i;
      s1_left_q  <= left_pad_pins_i;
    end
  end

  // port decode and state update
  assign sel  = port_sel_e'(s1_sel_q);
  assign mask = latch_q[0][MaskBit];
  assign ram_bit = ram_byp_q ? ram_byp_dat_q : ram_raw_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      latch_d[i] = latch_q[i];
    end
    color_d     = color_q;
    column_d    = column_q;
    row_d       = row_q;
    addr_d      = addr_q;
    wmode_d     = wmode_q;
    cmt_we      = 1'b0;
    rd_val_d    = '0;
    pix_we_d    = 1'b0;
    pix_row_d   = '0;
    pix_col_d   = '0;
    pix_color_d = '0;
    tone_we_d   = 1'b0;
    tone_val_d  = '0;
    if (s1_cmd_q == CmdRead) begin
      unique case (sel)
        PortPanel:  rd_val_d = ~s1_panel_q | latch_q[0];
        PortRight:  rd_val_d = ~(mask ? (s1_right_q | PadMaskOr) : s1_right_q) | latch_q[1];
        PortLeft:   rd_val_d = ~(mask ? BusIdle : s1_left_q) | latch_q[2];
        PortRow:    rd_val_d = latch_q[3];
        PortRamCtl: rd_val_d = wmode_q ? latch_q[4] : {ram_bit, latch_q[4][6:0]};
        PortRamAdr: rd_val_d = latch_q[5];
        default:    rd_val_d = BusIdle;
      endcase
    end else begin
      unique case (sel)
        PortPanel: begin
          latch_d[0] = s1_data_q;
          if (s1_data_q[PixelBit]) begin
            pix_we_d    = 1'b1;
            pix_row_d   = row_q;
            pix_col_d   = column_q;
            pix_color_d = color_q;
          end
        end
        PortRight: begin
          latch_d[1] = s1_data_q;
          color_d    = ~s1_data_q[7:6];
        end
        PortLeft: begin
          latch_d[2] = s1_data_q;
          column_d   = ~s1_data_q[ColW-1:0];
        end
        PortRow: begin
          latch_d[3] = s1_data_q;
          row_d      = ~s1_data_q[RowW-1:0];
          tone_we_d  = 1'b1;
          tone_val_d = s1_data_q[7:6];
        end
        PortRamCtl: begin
          latch_d[4] = s1_data_q;
          addr_d[2]  = s1_data_q[2];
          addr_d[3]  = s1_data_q[1];
          wmode_d    = s1_data_q[0];
          cmt_we     = s1_data_q[0];
        end
        PortRamAdr: begin
          latch_d[5] = s1_data_q;
          addr_d[9]  = s1_data_q[7];
          addr_d[8]  = s1_data_q[6];
          addr_d[7]  = s1_data_q[5];
          addr_d[1]  = s1_data_q[4];
          addr_d[6]  = s1_data_q[3];
          addr_d[5]  = s1_data_q[2];
          addr_d[4]  = s1_data_q[1];
          addr_d[0]  = s1_data_q[0];
        end
        default: ;
      endcase
    end
  end

  // state registers commit when the word moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        latch_q[i] <= '0;
      end
      color_q  <= '0;
      column_q <= '0;
      row_q    <= '0;
      addr_q   <= '0;
      wmode_q  <= 1'b0;
    end else if (s1_move) begin
      for (int i = 0; i < 6; i++) begin
        latch_q[i] <= latch_d[i];
      end
      color_q  <= color_d;
      column_q <= column_d;
      row_q    <= row_d;
      addr_q   <= addr_d;
      wmode_q  <= wmode_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      rd_val_q    <= rd_val_d;
      pix_we_q    <= pix_we_d;
      pix_row_q   <= pix_row_d;
      pix_col_q   <= pix_col_d;
      pix_color_q <= pix_color_d;
      tone_we_q   <= tone_we_d;
      tone_val_q  <= tone_val_d;
    end
  end

  // cart ram write: clearing pass, else committed write at the new address
  assign ram_we    = clearing | (s1_move & cmt_we);
  assign ram_waddr = clearing ? clr_cnt_q[RamAw-1:0] : addr_d;
  assign ram_wdat  = clearing ? 1'b0 : s1_data_q[3];

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_mem[ram_waddr] <= ram_wdat;
    end
    ram_raw_q <= ram_mem[s1_move ? addr_d : addr_q];
  end

  // bypass so the registered read always shows the addressed bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_byp_q     <= 1'b0;
      ram_byp_dat_q <= 1'b0;
    end else begin
      ram_byp_q     <= ram_we & (clearing | (ram_waddr == (s1_move ? addr_d : addr_q)));
      ram_byp_dat_q <= ram_wdat;
    end
  end

  // outputs
  assign out_valid_o    = out_valid_q;
  assign read_value_o   = rd_val_q;
  assign pixel_write_o  = pix_we_q;
  assign pixel_row_o    = pix_row_q;
  assign pixel_column_o = pix_col_q;
  assign pixel_color_o  = pix_color_q;
  assign tone_write_o   = tone_we_q;
  assign tone_value_o   = tone_val_q;

endmodule

// File: hw/rtl/cio_checker.sv
// ----------------------------------------------------------------------------
// cio_checker
// Port-level checks for the console I/O port block, bound to the top level.
// ----------------------------------------------------------------------------
module cio_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [7:0]                  read_value_o,
  input logic                        pixel_write_o,
  input logic [cio_pkg::RowW-1:0]    pixel_row_o,
  input logic [cio_pkg::ColW-1:0]    pixel_column_o,
  input logic [cio_pkg::ColorW-1:0]  pixel_color_o,
  input logic                        tone_write_o,
  input logic [cio_pkg::ToneW-1:0]   tone_value_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_value_o)
      && $stable(pixel_write_o) && $stable(tone_write_o))
    else $error("result word changed while stalled");

  // a pixel write and a tone write never come from the same word
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(pixel_write_o && tone_write_o))
    else $error("pixel and tone write together");

  // write words return a zero read byte
  a_wr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pixel_write_o || tone_write_o) |-> read_value_o == 8'h00)
    else $error("nonzero read byte on write word");

  // pixel fields are zero without a pixel write
  a_pix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pixel_write_o |->
      pixel_row_o == '0 && pixel_column_o == '0 && pixel_color_o == '0)
    else $error("pixel fields set without pixel write");

  // tone value is zero without a tone write
  a_tone_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tone_write_o |-> tone_value_o == '0)
    else $error("tone value set without tone write");

endmodule

bind console_io_port_block cio_checker u_cio_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .read_value_o   (read_value_o),
  .pixel_write_o  (pixel_write_o),
  .pixel_row_o    (pixel_row_o),
  .pixel_column_o (pixel_column_o),
  .pixel_color_o  (pixel_color_o),
  .tone_write_o   (tone_write_o),
  .tone_value_o   (tone_value_o)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the console I/O port block. A scoreboard keeps its
// own copy of the port latches, pixel registers and cart bit ram, predicts
// the result word of every accepted port access and compares it field by
// field with the words the block returns. Directed accesses cover the pin
// extremes, controller masking, pixel and tone writes, the cart ram and the
// unmapped selects; random pixel and ram sequences and single accesses follow
// under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import cio_pkg::*;

  // selects that no port decodes
  localparam logic [2:0] PortUnmapA = 3'd6;
  localparam logic [2:0] PortUnmapB = 3'd7;
  // cart ram control mode bit
  localparam logic CartWrite = 1'b1;
  localparam logic CartRead  = 1'b0;

  localparam int NumRandom = 1250;

  typedef struct {
    cmd_e       cmd;
    logic [2:0] sel;
    logic [7:0] wdata;
    logic [7:0] panel;
    logic [7:0] right;
    logic [7:0] left;
  } access_t;

  typedef struct {
    logic [7:0]        read_value;
    logic              pixel_write;
    logic [RowW-1:0]   pixel_row;
    logic [ColW-1:0]   pixel_column;
    logic [ColorW-1:0] pixel_color;
    logic              tone_write;
    logic [ToneW-1:0]  tone_value;
  } result_t;

  // predicts one result word per access and checks returned words in order
  class port_scoreboard;
    bit [7:0]        latch [6];
    bit [ColorW-1:0] color;
    bit [ColW-1:0]   column;
    bit [RowW-1:0]   row;
    bit              cart_ram [RamBits];
    bit [RamAw-1:0]  ram_addr;
    bit              wmode;
    result_t         results_due [$];
    int errors;
    int n_reads, n_writes, n_pixels, n_tones, n_ram_reads, n_unmapped;

    function void note_access(access_t a);
      result_t r;
      logic    masked;
      r = '{default: '0};
      masked = latch[PortPanel][MaskBit];
      if (a.sel > PortRamAdr) n_unmapped++;
      if (a.cmd == CmdRead) begin
        n_reads++;
        case (a.sel) inside
          PortPanel: r.read_value = ~a.panel | latch[PortPanel];
          PortRight: r.read_value = ~(masked ? (a.right | PadMaskOr) : a.right) | latch[PortRight];
          PortLeft:  r.read_value = ~(masked ? BusIdle : a.left) | latch[PortLeft];
          PortRow, PortRamAdr: r.read_value = latch[a.sel];
          PortRamCtl: begin
            if (wmode == CartWrite) begin
              r.read_value = latch[PortRamCtl];
            end else begin
              r.read_value = {cart_ram[ram_addr], latch[PortRamCtl][6:0]};
              n_ram_reads++;
            end
          end
          default: r.read_value = BusIdle;
        endcase
      end else begin
        n_writes++;
        if (a.sel <= PortRamAdr) latch[a.sel] = a.wdata;
        case (a.sel)
          PortPanel: begin
            if (a.wdata[PixelBit]) begin
              r.pixel_write  = 1'b1;
              r.pixel_row    = row;
              r.pixel_column = column;
              r.pixel_color  = color;
              n_pixels++;
            end
          end
          PortRight: color = ~a.wdata[7:6];
          PortLeft:  column = ~a.wdata[6:0];
          PortRow: begin
            row          = ~a.wdata[5:0];
            r.tone_write = 1'b1;
            r.tone_value = a.wdata[7:6];
            n_tones++;
          end
          PortRamCtl: begin
            ram_addr[2] = a.wdata[2];
            ram_addr[3] = a.wdata[1];
            wmode       = a.wdata[0];
            if (wmode == CartWrite) cart_ram[ram_addr] = a.wdata[3];
          end
          // address bits are scattered over the data byte
          PortRamAdr: ram_addr = {a.wdata[7:5], a.wdata[3:1], ram_addr[3:2], a.wdata[4], a.wdata[0]};
          default: ;
        endcase
      end
      results_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        $error("result word with nothing expected: read_value %0h", got.read_value);
        errors++;
        return;
      end
      want = results_due.pop_front();
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("pixel_write", 8'(want.pixel_write), 8'(got.pixel_write));
      compare_field("pixel_row", 8'(want.pixel_row), 8'(got.pixel_row));
      compare_field("pixel_column", 8'(want.pixel_column), 8'(got.pixel_column));
      compare_field("pixel_color", 8'(want.pixel_color), 8'(got.pixel_color));
      compare_field("tone_write", 8'(want.tone_write), 8'(got.tone_write));
      compare_field("tone_value", 8'(want.tone_value), 8'(got.tone_value));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              command_i = 1'b0;
  logic [2:0]        port_select_i = '0;
  logic [7:0]        write_value_i = '0;
  logic [7:0]        panel_pins_i = '0;
  logic [7:0]        right_pad_pins_i = '0;
  logic [7:0]        left_pad_pins_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        read_value_o;
  logic              pixel_write_o;
  logic [RowW-1:0]   pixel_row_o;
  logic [ColW-1:0]   pixel_column_o;
  logic [ColorW-1:0] pixel_color_o;
  logic              tone_write_o;
  logic [ToneW-1:0]  tone_value_o;

  port_scoreboard sb = new();
  result_t        seen_word;
  bit             quiet = 1'b0;
  int             items_sent = 0;
  int             stall_left = 0;
  int             stall_pick;

  console_io_port_block dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .port_select_i    (port_select_i),
    .write_value_i    (write_value_i),
    .panel_pins_i     (panel_pins_i),
    .right_pad_pins_i (right_pad_pins_i),
    .left_pad_pins_i  (left_pad_pins_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_value_o     (read_value_o),
    .pixel_write_o    (pixel_write_o),
    .pixel_row_o      (pixel_row_o),
    .pixel_column_o   (pixel_column_o),
    .pixel_color_o    (pixel_color_o),
    .tone_write_o     (tone_write_o),
    .tone_value_o     (tone_value_o)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // gap before the next input word: mostly none, a few long
  function automatic int pick_gap();
    int pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // pin values with the extremes weighted up
  function automatic logic [7:0] pick_pins();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  // drive one word and hold it until accepted
  task automatic send_word(input access_t a);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= a.cmd;
    port_select_i    <= a.sel;
    write_value_i    <= a.wdata;
    panel_pins_i     <= a.panel;
    right_pad_pins_i <= a.right;
    left_pad_pins_i  <= a.left;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_access(a);
    items_sent++;
  endtask

  // access with random pin levels
  task automatic issue(input cmd_e cmd, input logic [2:0] sel, input logic [7:0] wdata);
    access_t a;
    a.cmd   = cmd;
    a.sel   = sel;
    a.wdata = wdata;
    a.panel = pick_pins();
    a.right = pick_pins();
    a.left  = pick_pins();
    send_word(a);
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) begin
        out_stall_i <= 1'b0;
      end else begin
        stall_left = (stall_pick < 93) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_stall_i <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      seen_word.read_value   = read_value_o;
      seen_word.pixel_write  = pixel_write_o;
      seen_word.pixel_row    = pixel_row_o;
      seen_word.pixel_column = pixel_column_o;
      seen_word.pixel_color  = pixel_color_o;
      seen_word.tone_write   = tone_write_o;
      seen_word.tone_value   = tone_value_o;
      sb.check_word(seen_word);
    end
  end

  // run limit, allows for the ram clearing pass and heavy stalls
  initial begin
    #5000000;
    $display("tb_top NOT OK");
    $finish;
  end

  // stimulus
  initial begin
    logic [7:0] adr_pool [4];
    logic [7:0] adr;
    logic [3:0] ctl_hi;
    logic [1:0] a23;
    logic       dbit;
    logic [2:0] sel;
    int         pick;
    int         chunk;

    foreach (adr_pool[i]) adr_pool[i] = 8'($urandom);
    chunk = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pin extremes and reset contents
    send_word('{CmdRead, PortPanel, 8'h00, 8'h00, 8'h00, 8'h00});
    send_word('{CmdRead, PortPanel, 8'h00, 8'hff, 8'h00, 8'h00});
    send_word('{CmdRead, PortRight, 8'h00, 8'h00, 8'h00, 8'h00});
    send_word('{CmdRead, PortLeft, 8'h00, 8'h00, 8'h00, 8'hff});
    send_word('{CmdRead, PortRow, 8'h00, 8'h00, 8'h00, 8'h00});
    send_word('{CmdRead, PortRamCtl, 8'h00, 8'h00, 8'h00, 8'h00});
    send_word('{CmdRead, PortRamAdr, 8'h00, 8'h00, 8'h00, 8'h00});
    // unmapped selects
    send_word('{CmdRead, PortUnmapA, 8'h00, 8'h00, 8'h00, 8'h00});
    send_word('{CmdWrite, PortUnmapB, 8'hff, 8'hff, 8'hff, 8'hff});
    // full color, column and row, then a pixel write and the mask
    send_word('{CmdWrite, PortRight, 8'h3f, 8'h00, 8'h00, 8'h00});
    send_word('{CmdWrite, PortLeft, 8'h80, 8'h00, 8'h00, 8'h00});
    send_word('{CmdWrite, PortRow, 8'hc0, 8'h00, 8'h00, 8'h00});
    send_word('{CmdWrite, PortPanel, 8'h20, 8'h00, 8'h00, 8'h00});
    send_word('{CmdWrite, PortPanel, 8'h40, 8'h00, 8'h00, 8'h00});
    send_word('{CmdRead, PortRight, 8'h00, 8'h00, 8'h00, 8'h00});
    send_word('{CmdRead, PortLeft, 8'h00, 8'h00, 8'h00, 8'h00});
    // zero registers, pixel with the mask still set
    send_word('{CmdWrite, PortRight, 8'hff, 8'h00, 8'h00, 8'h00});
    send_word('{CmdWrite, PortLeft, 8'h7f, 8'h00, 8'h00, 8'h00});
    send_word('{CmdWrite, PortRow, 8'h3f, 8'h00, 8'h00, 8'h00});
    send_word('{CmdWrite, PortPanel, 8'hff, 8'hff, 8'hff, 8'hff});
    // cart ram: top address, write mode read, read mode read, other address
    send_word('{CmdWrite, PortRamAdr, 8'hff, 8'h00, 8'h00, 8'h00});
    send_word('{CmdWrite, PortRamCtl, 8'h0f, 8'h00, 8'h00, 8'h00});
    send_word('{CmdRead, PortRamCtl, 8'h00, 8'h00, 8'h00, 8'h00});
    send_word('{CmdWrite, PortRamCtl, 8'h06, 8'h00, 8'h00, 8'h00});
    send_word('{CmdRead, PortRamCtl, 8'h00, 8'h00, 8'h00, 8'h00});
    send_word('{CmdWrite, PortRamAdr, 8'h00, 8'h00, 8'h00, 8'h00});
    send_word('{CmdRead, PortRamCtl, 8'h00, 8'h00, 8'h00, 8'h00});

    // random pixel and ram sequences mixed with single accesses
    items_sent = 0;
    while (items_sent < NumRandom) begin
      if (items_sent / 100 != chunk) begin
        chunk = items_sent / 100;
        quiet = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        issue(CmdWrite, PortRight, 8'($urandom));
        issue(CmdWrite, PortLeft, 8'($urandom));
        if ($urandom_range(0, 2) == 0) issue(CmdRead, PortPanel, 8'($urandom));
        issue(CmdWrite, PortRow, 8'($urandom));
        issue(CmdWrite, PortPanel, 8'($urandom) | (8'h01 << PixelBit));
      end else if (pick < 35) begin
        if ($urandom_range(0, 15) == 0) adr_pool[2'($urandom_range(0, 3))] = 8'($urandom);
        adr    = adr_pool[2'($urandom_range(0, 3))];
        ctl_hi = 4'($urandom);
        a23    = 2'($urandom);
        dbit   = 1'($urandom);
        issue(CmdWrite, PortRamAdr, adr);
        if ($urandom_range(0, 3) != 0) issue(CmdWrite, PortRamCtl, {ctl_hi, dbit, a23, CartWrite});
        if ($urandom_range(0, 3) == 0) issue(CmdRead, PortRamCtl, 8'($urandom));
        issue(CmdWrite, PortRamCtl, {ctl_hi, 1'($urandom), a23, CartRead});
        issue(CmdRead, PortRamCtl, 8'($urandom));
      end else begin
        if ($urandom_range(0, 19) == 0) sel = $urandom_range(0, 1) ? PortUnmapA : PortUnmapB;
        else sel = 3'($urandom_range(PortPanel, PortRamAdr));
        issue(cmd_e'($urandom_range(0, 1)), sel, 8'($urandom));
      end
    end

    // drain
    in_valid_i <= 1'b0;
    quiet = 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d reads and %0d writes, %0d pixel writes, %0d tone writes",
             sb.n_reads, sb.n_writes, sb.n_pixels, sb.n_tones);
    $display("cart ram bits read back %0d times, unmapped selects hit %0d times",
             sb.n_ram_reads, sb.n_unmapped);
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/cio_pkg.sv
hw/rtl/console_io_port_block.sv
hw/rtl/cio_checker.sv
tb/tb_top.sv
